// ===== rtl/world_to_screen_projection_unit_macros.svh =====
// Assertion macros shared by the projection unit. The clock and reset are
// taken from the scope in which a macro is used.
`ifndef WORLD_TO_SCREEN_PROJECTION_UNIT_MACROS_SVH
`define WORLD_TO_SCREEN_PROJECTION_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define WSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define WSP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WSP_ASSERT(lbl, prop, msg)
`define WSP_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/wsp_pkg.sv =====
package wsp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int DIM_W     = 14;
  localparam int NCOEF     = 32;
  localparam int ADDR_W    = $clog2(NCOEF);
  localparam int PADDR_W   = 3;

  // Operands of the shared multiplier are one bit wider than the data so that
  // the viewport terms (ndc + 1.0 and 1.0 - ndc) fit without overflow.
  localparam int OPND_W    = DATA_W + 1;
  localparam int PROD_W    = 2 * OPND_W;
  localparam int ACC_W     = PROD_W + 2;

  // Divider: the numerator magnitude is |c| scaled by 2^FRAC_BITS.
  localparam int NUM_W     = DATA_W + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(NUM_W + 1);

  // Matrix pass: 16 product issues, then the pipeline drains.
  localparam int MAT_ISSUES = 16;
  localparam int MAT_LAST   = MAT_ISSUES + 3;
  localparam int CNT_W      = $clog2(MAT_LAST + 1);

  localparam logic signed [DATA_W-1:0] FX_ONE     = DATA_W'(1) << FRAC_BITS;
  localparam logic signed [DATA_W-1:0] FX_NEG_ONE = -FX_ONE;
  localparam logic signed [DATA_W-1:0] S32_MAX    = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] S32_MIN    = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_PROJECT = 1'b1
  } cmd_t;

  typedef enum logic {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VIEW,
    ST_PROJ,
    ST_DIVX,
    ST_DIVY,
    ST_MAP,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                     en;
    logic                     first;
    logic signed [OPND_W-1:0] a;
    logic signed [OPND_W-1:0] b;
  } mac_req_t;

  typedef struct packed {
    logic                     start;
    logic signed [DATA_W-1:0] numer;
    logic signed [DATA_W-1:0] denom;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic       en;
    logic       first;
    logic       last;
    logic [1:0] i;
    logic [1:0] j;
  } tag_t;

  // Clamp a wide signed value to the 32-bit signed range.
  function automatic logic signed [DATA_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > ACC_W'(S32_MAX)) begin
      r = S32_MAX;
    end else if (v < ACC_W'(S32_MIN)) begin
      r = S32_MIN;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/wsp_coef_mem.sv =====
// Coefficient store: one write port, one registered read port. Entries that
// were never written since reset read as zero.
module wsp_coef_mem import wsp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     we,
  input  logic [ADDR_W-1:0]        waddr,
  input  logic signed [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0]        raddr,
  output logic signed [DATA_W-1:0] rdata
);

  logic signed [DATA_W-1:0] mem [NCOEF];
  logic [NCOEF-1:0]         written;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (we) begin
      written[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= written[raddr] ? mem[raddr] : '0;
  end

endmodule

// ===== rtl/wsp_mac.sv =====
// Shared multiply-accumulate unit: a registered product, then a registered
// accumulator that restarts from zero on a request marked first.
module wsp_mac import wsp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  mac_req_t                req,
  output logic signed [ACC_W-1:0] acc
);

  logic signed [PROD_W-1:0] prod;
  logic                     prod_en;
  logic                     prod_first;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_en <= 1'b0;
    end else begin
      prod_en <= req.en;
    end
  end

  always_ff @(posedge clk) begin
    prod_first <= req.first;
    prod       <= $signed(req.a) * $signed(req.b);
    if (prod_en) begin
      acc <= (prod_first ? ACC_W'(0) : acc) + ACC_W'(prod);
    end
  end

endmodule

// ===== rtl/wsp_div.sv =====
// Restoring divider, one quotient bit per cycle. Computes
// (numer * 2^FRAC_BITS) / denom truncated towards zero for a positive denom,
// and clamps the quotient to the 32-bit signed range.
module wsp_div import wsp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  div_req_t                 req,
  output div_stat_t                stat,
  output logic signed [DATA_W-1:0] quot
);

  logic                     busy;
  logic                     done;
  logic [DIV_CNT_W-1:0]     cnt;
  logic                     neg;
  logic [NUM_W-1:0]         dvd;
  logic [DATA_W-2:0]        rem;
  logic [DATA_W-2:0]        dsr;

  logic [DATA_W-1:0]        mag;
  logic [DATA_W-1:0]        shifted;
  logic [DATA_W-1:0]        diff;
  logic                     fits;
  logic [DATA_W-2:0]        rem_next;
  logic [NUM_W-1:0]         q_final;
  logic                     q_big;
  logic signed [DATA_W-1:0] q_sat;

  always_comb begin
    mag      = req.numer[DATA_W-1] ? (~req.numer + DATA_W'(1)) : req.numer;
    shifted  = {rem, dvd[NUM_W-1]};
    diff     = shifted - {1'b0, dsr};
    fits     = shifted >= {1'b0, dsr};
    rem_next = fits ? diff[DATA_W-2:0] : shifted[DATA_W-2:0];
    q_final  = {dvd[NUM_W-2:0], fits};
    q_big    = q_final[NUM_W-1:DATA_W-1] != '0;
    if (neg) begin
      q_sat = q_big ? S32_MIN : -q_final[DATA_W-1:0];
    end else begin
      q_sat = q_big ? S32_MAX : q_final[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg <= req.numer[DATA_W-1];
      dvd <= {mag, {FRAC_BITS{1'b0}}};
      rem <= '0;
      dsr <= req.denom[DATA_W-2:0];
    end else if (busy) begin
      dvd <= q_final;
      rem <= rem_next;
      if (cnt == DIV_CNT_W'(NUM_W - 1)) begin
        quot <= q_sat;
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== rtl/world_to_screen_projection_unit.sv =====
// World-to-screen projection unit. Requests on the input channel either load
// one signed Q16.16 matrix coefficient (indices 0 to 15 form the view matrix,
// 16 to 31 the projection matrix, both row-major) or project a world point.
// A load produces no result. A projection multiplies the
// row vector [x y z 1] by the view matrix and then by the projection matrix,
// divides clip x and y by clip w, and maps them onto a screen of
// screen_width by screen_height pixels with y flipped; it produces exactly one
// result. When clip w is zero or negative the result is (-1.0, -1.0) with
// behind_camera set. The input stays not ready from the acceptance of a
// projection until its result is ready, which comes sooner for a point
// behind the camera, and for as long again as the previous result still
// waits in the output register. The wait for a result comes from
// the two serial divisions, each retiring one quotient bit per cycle over 48
// bits, and from the single shared multiplier, which works through all 32
// matrix products one per cycle and then the two viewport products. A
// finished result sits in the output register while the next request is
// accepted. The coefficient store reads as all zero after reset. The screen
// size registers sit at byte address 0 (width) and 4 (height) of the APB port
// and reset to 1920 and 1080.
`include "world_to_screen_projection_unit_macros.svh"

module world_to_screen_projection_unit import wsp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,

  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready,

  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     command,
  input  logic [ADDR_W-1:0]        coeff_index,
  input  logic signed [DATA_W-1:0] coeff_value,
  input  logic signed [DATA_W-1:0] world_x,
  input  logic signed [DATA_W-1:0] world_y,
  input  logic signed [DATA_W-1:0] world_z,

  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] screen_x,
  output logic signed [DATA_W-1:0] screen_y,
  output logic                     behind_camera
);

  // Configuration registers.
  logic [DIM_W-1:0] screen_width;
  logic [DIM_W-1:0] screen_height;
  logic             cfg_write;

  // Sequencer.
  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             in_accept;
  logic             out_load;
  logic             mat_phase;

  // Datapath.
  logic signed [DATA_W-1:0] vec [4];
  logic signed [DATA_W-1:0] res [4];
  logic signed [DATA_W-1:0] nx;
  logic signed [DATA_W-1:0] sx;
  logic signed [DATA_W-1:0] sy;
  logic                     behind;
  logic                     w_nonpos;

  tag_t                     issue;
  tag_t                     tag_pipe [3];
  logic [ADDR_W-1:0]        raddr;
  logic signed [DATA_W-1:0] rd_coef;

  mac_req_t                 mac_req;
  logic signed [ACC_W-1:0]  acc;
  div_req_t                 div_req;
  div_stat_t                div_stat;
  logic signed [DATA_W-1:0] div_quot;

  // ---------------------------------------------------------------------
  // APB configuration port. The port never stalls; the register is chosen
  // by address bit 2 and the low address bits are ignored.
  // ---------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= DIM_W'(1920);
      screen_height <= DIM_W'(1080);
    end else if (cfg_write) begin
      unique case (reg_idx_t'(paddr[2]))
        REG_SCREEN_WIDTH:  screen_width  <= pwdata[DIM_W-1:0];
        REG_SCREEN_HEIGHT: screen_height <= pwdata[DIM_W-1:0];
        default:           screen_width  <= screen_width;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[2]))
      REG_SCREEN_WIDTH:  prdata = DATA_W'(screen_width);
      REG_SCREEN_HEIGHT: prdata = DATA_W'(screen_height);
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Shared units.
  // ---------------------------------------------------------------------
  wsp_coef_mem u_coef_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (in_accept && (command == CMD_LOAD)),
    .waddr (coeff_index),
    .wdata (coeff_value),
    .raddr (raddr),
    .rdata (rd_coef)
  );

  wsp_mac u_mac (
    .clk (clk),
    .rst (rst),
    .req (mac_req),
    .acc (acc)
  );

  wsp_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .stat (div_stat),
    .quot (div_quot)
  );

  // ---------------------------------------------------------------------
  // Sequencer. In a matrix pass the counter walks the 16 coefficients with
  // the row index i inner and the output column j outer, so each column's
  // four products reach the accumulator back to back. The tag pipeline
  // follows each product through the coefficient read, the product register
  // and the accumulator, and the column is written once its last term lands.
  // ---------------------------------------------------------------------
  assign in_accept = in_valid && in_ready;
  assign mat_phase = (state == ST_VIEW) || (state == ST_PROJ);
  assign w_nonpos  = res[3][DATA_W-1] || (res[3] == '0);
  assign out_load  = (state == ST_OUT) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    in_ready   = (state == ST_IDLE);

    issue       = '0;
    issue.i     = cnt[1:0];
    issue.j     = cnt[3:2];
    issue.first = (cnt[1:0] == 2'd0);
    issue.last  = (cnt[1:0] == 2'd3);
    issue.en    = mat_phase && (cnt < CNT_W'(MAT_ISSUES));
    raddr       = {state == ST_PROJ, cnt[1:0], cnt[3:2]};

    mac_req.en    = tag_pipe[0].en;
    mac_req.first = tag_pipe[0].first;
    mac_req.a     = OPND_W'(vec[tag_pipe[0].i]);
    mac_req.b     = OPND_W'(rd_coef);

    div_req.start = 1'b0;
    div_req.numer = (state == ST_DIVY) ? res[1] : res[0];
    div_req.denom = res[3];

    unique case (state)
      ST_IDLE: begin
        if (in_valid && (command == CMD_PROJECT)) begin
          state_next = ST_VIEW;
          cnt_next   = '0;
        end
      end
      ST_VIEW: begin
        cnt_next = cnt + CNT_W'(1);
        if (cnt == CNT_W'(MAT_LAST)) begin
          state_next = ST_PROJ;
          cnt_next   = '0;
        end
      end
      ST_PROJ: begin
        cnt_next = cnt + CNT_W'(1);
        if (cnt == CNT_W'(MAT_LAST)) begin
          state_next = w_nonpos ? ST_OUT : ST_DIVX;
          cnt_next   = '0;
        end
      end
      ST_DIVX: begin
        if (cnt == '0) begin
          div_req.start = 1'b1;
          cnt_next      = CNT_W'(1);
        end else if (div_stat.done) begin
          state_next = ST_DIVY;
          cnt_next   = '0;
        end
      end
      ST_DIVY: begin
        if (cnt == '0) begin
          div_req.start = 1'b1;
          cnt_next      = CNT_W'(1);
        end else if (div_stat.done) begin
          state_next = ST_MAP;
          cnt_next   = '0;
        end
      end
      ST_MAP: begin
        // Two viewport products: (ndc_x + 1.0) * width, then
        // (1.0 - ndc_y) * height. Each is read back after the product and accumulator registers.
        cnt_next = cnt + CNT_W'(1);
        if (cnt == CNT_W'(0)) begin
          mac_req.en    = 1'b1;
          mac_req.first = 1'b1;
          mac_req.a     = OPND_W'(nx) + OPND_W'(FX_ONE);
          mac_req.b     = OPND_W'(screen_width);
        end else if (cnt == CNT_W'(1)) begin
          mac_req.en    = 1'b1;
          mac_req.first = 1'b1;
          mac_req.a     = OPND_W'(FX_ONE) - OPND_W'(div_quot);
          mac_req.b     = OPND_W'(screen_height);
        end else if (cnt == CNT_W'(3)) begin
          state_next = ST_OUT;
          cnt_next   = '0;
        end
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
        cnt_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_pipe[0] <= '0;
      tag_pipe[1] <= '0;
      tag_pipe[2] <= '0;
    end else begin
      tag_pipe[0] <= issue;
      tag_pipe[1] <= tag_pipe[0];
      tag_pipe[2] <= tag_pipe[1];
    end
  end

  // ---------------------------------------------------------------------
  // Datapath registers. The view pass result becomes the input vector of
  // the projection pass. Each column sum is floored by the fraction width
  // and clamped to 32 bits.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_accept && (command == CMD_PROJECT)) begin
      vec[0] <= world_x;
      vec[1] <= world_y;
      vec[2] <= world_z;
      vec[3] <= FX_ONE;
    end else if ((state == ST_VIEW) && (cnt == CNT_W'(MAT_LAST))) begin
      vec[0] <= res[0];
      vec[1] <= res[1];
      vec[2] <= res[2];
      vec[3] <= res[3];
    end

    if (tag_pipe[2].en && tag_pipe[2].last) begin
      res[tag_pipe[2].j] <= sat_acc(acc >>> FRAC_BITS);
    end

    if ((state == ST_PROJ) && (cnt == CNT_W'(MAT_LAST))) begin
      behind <= w_nonpos;
      sx     <= FX_NEG_ONE;
      sy     <= FX_NEG_ONE;
    end

    if ((state == ST_DIVX) && (cnt != '0) && div_stat.done) begin
      nx <= div_quot;
    end

    // The viewport product is halved with a floor before clamping.
    if ((state == ST_MAP) && (cnt == CNT_W'(2))) begin
      sx <= sat_acc(acc >>> 1);
    end
    if ((state == ST_MAP) && (cnt == CNT_W'(3))) begin
      sy <= sat_acc(acc >>> 1);
    end

    if (out_load) begin
      screen_x      <= sx;
      screen_y      <= sy;
      behind_camera <= behind;
    end
  end

  // Output register: holds a result until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  `WSP_ASSERT(a_proj_goes_busy, (in_accept && (command == CMD_PROJECT)) |=> !in_ready, "projection request did not make the block busy")
  `WSP_ASSERT(a_behind_coords, (out_valid && behind_camera) |-> (screen_x == FX_NEG_ONE && screen_y == FX_NEG_ONE), "behind-camera result without -1.0 coordinates")
  `WSP_ASSERT(a_div_positive, div_req.start |-> (!res[3][DATA_W-1] && (res[3] != '0)), "division started with a non-positive clip w")
  `WSP_ASSERT(a_result_source, $rose(out_valid) |-> $past(state == ST_OUT), "result appeared outside the output state")
  `WSP_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == ST_IDLE && !out_valid), "reset did not return the block to idle")

endmodule

// ===== test/testbench.sv =====
module testbench;
  import wsp_pkg::*;

  // Quiet cycles after the last result; more than a projection needs in the block,
  // so any request still in flight can finish.
  localparam int SETTLE_CYCLES = 200;
  localparam int VIEW_BASE     = 0;
  localparam int PROJ_BASE     = 16;
  localparam int REPORT_LIMIT  = 10;

  typedef logic signed [DATA_W-1:0] fx_t;
  typedef fx_t [3:0] vec4_t;

  // One screen position as the block should report it.
  typedef struct {
    fx_t  sx;
    fx_t  sy;
    logic behind;
  } pixel_t;

  logic                     clk;
  logic                     rst;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [PADDR_W-1:0]       paddr;
  logic [DATA_W-1:0]        pwdata;
  logic [DATA_W-1:0]        prdata;
  logic                     pready;
  logic                     in_valid;
  logic                     in_ready;
  logic                     command;
  logic [ADDR_W-1:0]        coeff_index;
  logic signed [DATA_W-1:0] coeff_value;
  logic signed [DATA_W-1:0] world_x;
  logic signed [DATA_W-1:0] world_y;
  logic signed [DATA_W-1:0] world_z;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [DATA_W-1:0] screen_x;
  logic signed [DATA_W-1:0] screen_y;
  logic                     behind_camera;

  // Our own copy of the block's state: the matrix coefficients and the
  // viewport size. Both are updated at the clock edge at which the block
  // takes the matching request or register write.
  fx_t              coeff_mirror [NCOEF];
  logic [DIM_W-1:0] width_mirror;
  logic [DIM_W-1:0] height_mirror;

  // Screen positions still owed by the block, oldest first.
  pixel_t pending_pixels [$];

  int mismatch_count;
  bit no_gaps;

  world_to_screen_projection_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .coeff_index   (coeff_index),
    .coeff_value   (coeff_value),
    .world_x       (world_x),
    .world_y       (world_y),
    .world_z       (world_z),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .screen_x      (screen_x),
    .screen_y      (screen_y),
    .behind_camera (behind_camera)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A run that hangs is cut off here. The slowest honest run needs well under
  // a tenth of this time.
  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Clamps a wide signed value to the 32-bit signed range.
  function automatic fx_t clamp32(input logic signed [67:0] v);
    if (v > 68'(S32_MAX)) begin
      return S32_MAX;
    end
    if (v < 68'(S32_MIN)) begin
      return S32_MIN;
    end
    return v[DATA_W-1:0];
  endfunction

  // Multiplies a row vector by one of the two stored 4x4 matrices. The four
  // exact products of each column are summed before the fraction is floored
  // away, and the sum is then clamped to 32 bits.
  function automatic vec4_t transform_row(input vec4_t v, input int base);
    vec4_t               r;
    logic signed [67:0]  acc;
    int                  i;
    int                  j;
    for (j = 0; j < 4; j++) begin
      acc = '0;
      for (i = 0; i < 4; i++) begin
        acc = acc + longint'($signed(v[i])) *
                    longint'($signed(coeff_mirror[base + 4 * i + j]));
      end
      r[j] = clamp32(acc >>> FRAC_BITS);
    end
    return r;
  endfunction

  // Works out the screen position of one world point from the current
  // matrices and viewport size.
  function automatic pixel_t predict_pixel(input fx_t x, input fx_t y, input fx_t z);
    pixel_t  p;
    vec4_t   eye;
    vec4_t   clip;
    longint  w;
    longint  one;
    longint  nx;
    longint  ny;
    one  = longint'(1) << FRAC_BITS;
    eye  = transform_row({FX_ONE, z, y, x}, VIEW_BASE);
    clip = transform_row(eye, PROJ_BASE);
    w    = longint'($signed(clip[3]));
    if (w <= 0) begin
      // The point lies behind the camera, or exactly in its plane.
      p.sx     = FX_NEG_ONE;
      p.sy     = FX_NEG_ONE;
      p.behind = 1'b1;
      return p;
    end
    // Longint division truncates toward zero, which is what the block does.
    nx = longint'(clamp32(longint'($signed(clip[0])) * one / w));
    ny = longint'(clamp32(longint'($signed(clip[1])) * one / w));
    p.sx     = clamp32(((nx + one) * longint'(width_mirror)) >>> 1);
    p.sy     = clamp32(((one - ny) * longint'(height_mirror)) >>> 1);
    p.behind = 1'b0;
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  function automatic void flag_mismatch(input string what, input longint want,
                                        input longint got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("mismatch in %s: expected %0d, got %0d", what, want, got);
    end
  endfunction

  pixel_t want_pixel;

  // Every result the block hands over is held against the oldest position
  // still owed. Outputs are read at the rising edge, before the block's own
  // updates for that edge land.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        flag_mismatch("unrequested result, screen_x", 0, screen_x);
      end else begin
        want_pixel = pending_pixels.pop_front();
        if (screen_x !== want_pixel.sx) begin
          flag_mismatch("screen_x", want_pixel.sx, screen_x);
        end
        if (screen_y !== want_pixel.sy) begin
          flag_mismatch("screen_y", want_pixel.sy, screen_y);
        end
        if (behind_camera !== want_pixel.behind) begin
          flag_mismatch("behind_camera", want_pixel.behind, behind_camera);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake helpers
  // ---------------------------------------------------------------------------

  // Idle length for either side: mostly none, often a short one, now and
  // then a long pause. One scene switches gaps off altogether.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_gaps || r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(3, 1);
    end
    return $urandom_range(40, 10);
  endfunction

  // The receiving side stalls at random. Stalls start on any cycle, so they
  // fall on every phase of the block's work, including the output hold.
  initial begin : result_backpressure
    int stall;
    stall     = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ready = 1'b0;
        stall--;
      end else begin
        out_ready = 1'b1;
        if ($urandom_range(4) == 0) begin
          stall = pick_gap();
        end
      end
    end
  end

  // Sends one request and waits for the block to take it. Valid stays high
  // from one request into the next when no gap is chosen. The expected result
  // is worked out at the edge at which the request is taken.
  task automatic send_request(input cmd_t cmd, input logic [ADDR_W-1:0] idx,
                              input fx_t value, input fx_t x, input fx_t y,
                              input fx_t z);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    command     = cmd;
    coeff_index = idx;
    coeff_value = value;
    world_x     = x;
    world_y     = y;
    world_z     = z;
    in_valid    = 1'b1;
    do @(posedge clk); while (!in_ready);
    if (cmd == CMD_LOAD) begin
      coeff_mirror[idx] = value;
    end else begin
      pending_pixels.push_back(predict_pixel(x, y, z));
    end
  endtask

  // A load carries junk in the point fields, and a projection carries junk in
  // the coefficient fields; the block has to ignore both.
  task automatic load_coeff(input int idx, input fx_t value);
    send_request(CMD_LOAD, ADDR_W'(idx), value,
                 fx_t'($urandom), fx_t'($urandom), fx_t'($urandom));
  endtask

  task automatic project(input fx_t x, input fx_t y, input fx_t z);
    send_request(CMD_PROJECT, ADDR_W'($urandom), fx_t'($urandom), x, y, z);
  endtask

  // Holds the sender until every owed result has arrived, then lets the block
  // settle so that register writes only ever meet an idle block.
  task automatic wait_until_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: a setup cycle, then an access cycle that ends on pready.
  task automatic write_screen_reg(input reg_idx_t which, input logic [DATA_W-1:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {which, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (which == REG_SCREEN_WIDTH) begin
      width_mirror = data[DIM_W-1:0];
    end else begin
      height_mirror = data[DIM_W-1:0];
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // APB read, checked against our copy of the register.
  task automatic check_screen_reg(input reg_idx_t which);
    logic [DATA_W-1:0] want;
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {which, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    want = (which == REG_SCREEN_WIDTH) ? DATA_W'(width_mirror) : DATA_W'(height_mirror);
    if (prdata !== want) begin
      flag_mismatch(which == REG_SCREEN_WIDTH ? "screen_width read" : "screen_height read",
                    want, prdata);
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus sources
  // ---------------------------------------------------------------------------

  function automatic fx_t rand_between(input int lo, input int hi);
    return fx_t'(lo + int'($urandom_range(hi - lo)));
  endfunction

  // A viewport size, with the edges of the 14-bit range well represented.
  // Half of the writes also carry junk above the register's width.
  function automatic logic [DATA_W-1:0] pick_screen_size();
    logic [DIM_W-1:0] size;
    case ($urandom_range(9))
      0: size = '0;
      1: size = DIM_W'(1);
      2: size = DIM_W'(8192);
      3: size = '1;
      default: size = DIM_W'($urandom_range(8192, 1));
    endcase
    if ($urandom_range(1) == 1) begin
      return {(DATA_W-DIM_W)'($urandom), size};
    end
    return DATA_W'(size);
  endfunction

  // One coefficient of a plausible camera. The view matrix is a slightly
  // skewed rotation with a translation in its bottom row; the projection is
  // a perspective matrix whose last column copies view z into clip w.
  function automatic fx_t camera_coeff(input int idx);
    int row;
    int col;
    row = (idx % 16) / 4;
    col = idx % 4;
    if (idx < PROJ_BASE) begin
      if (col == 3) begin
        return (row == 3) ? FX_ONE : '0;
      end
      if (row == 3) begin
        return rand_between(-10 * FX_ONE, 10 * FX_ONE);
      end
      if (row == col) begin
        return rand_between(3 * FX_ONE / 4, 5 * FX_ONE / 4);
      end
      return rand_between(-FX_ONE / 4, FX_ONE / 4);
    end
    case (idx - PROJ_BASE)
      0, 5:    return rand_between(FX_ONE / 2, 3 * FX_ONE);
      10:      return rand_between(9 * FX_ONE / 10, 11 * FX_ONE / 10);
      11:      return FX_ONE;
      14:      return rand_between(-2 * FX_ONE, -FX_ONE / 20);
      default: return '0;
    endcase
  endfunction

  task automatic load_matrices(input bit plausible);
    int idx;
    for (idx = 0; idx < NCOEF; idx++) begin
      load_coeff(idx, plausible ? camera_coeff(idx) : rand_between(-2 * FX_ONE, 2 * FX_ONE));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Registers read back their reset values, and with an all-zero store clip w
  // is zero, so the first point must come back as behind the camera.
  task automatic test_reset_state();
    check_screen_reg(REG_SCREEN_WIDTH);
    check_screen_reg(REG_SCREEN_HEIGHT);
    project('0, '0, '0);
  endtask

  // Identity view with a projection that puts view z into clip w, followed by
  // points that hit the centre, the corner, saturation in each stage, and a
  // negative w.
  task automatic test_directed_cases();
    load_coeff(0, FX_ONE);
    load_coeff(5, FX_ONE);
    load_coeff(10, FX_ONE);
    load_coeff(15, FX_ONE);
    load_coeff(16, FX_ONE);
    load_coeff(21, FX_ONE);
    load_coeff(26, FX_ONE);
    load_coeff(27, FX_ONE);
    project('0, '0, FX_ONE);
    project(FX_ONE, FX_ONE, FX_ONE);
    project(S32_MAX, S32_MIN, FX_ONE);
    // A w of one least significant bit drives both divisions into saturation.
    project(FX_ONE, FX_NEG_ONE, fx_t'(1));
    project('0, '0, FX_NEG_ONE);
    project(S32_MIN, S32_MAX, S32_MAX);
    // Extreme translations saturate the view stage.
    load_coeff(12, S32_MAX);
    project(FX_ONE, '0, FX_ONE);
    load_coeff(12, S32_MIN);
    project(FX_ONE, '0, FX_ONE);
    load_coeff(12, '0);
    // A hugely negative w offset puts every ordinary point behind the camera.
    load_coeff(31, S32_MIN);
    project('0, '0, FX_ONE);
    load_coeff(31, '0);
  endtask

  // Writes one viewport size, reads it back and projects two points through
  // the identity camera left by the directed test.
  task automatic try_screen_size(input int w, input int h);
    wait_until_idle();
    write_screen_reg(REG_SCREEN_WIDTH, {(DATA_W-DIM_W)'($urandom), DIM_W'(w)});
    write_screen_reg(REG_SCREEN_HEIGHT, {(DATA_W-DIM_W)'($urandom), DIM_W'(h)});
    check_screen_reg(REG_SCREEN_WIDTH);
    check_screen_reg(REG_SCREEN_HEIGHT);
    project(FX_ONE / 2, FX_ONE / 4, FX_ONE);
    project(FX_NEG_ONE, FX_ONE, 2 * FX_ONE);
  endtask

  // A zero size must map every visible point to zero on that axis, and the
  // largest 14-bit size must not wrap.
  task automatic test_screen_sizes();
    try_screen_size(0, 16383);
    try_screen_size(1, 1);
    try_screen_size(8192, 8192);
    try_screen_size(16383, 0);
    try_screen_size(640, 480);
  endtask

  // Most scenes load a plausible camera and project points around it, so that
  // the divisions and the viewport mapping see real work. Stray loads and
  // points drawn from the full 32-bit range are mixed in as noise. Each scene
  // starts by holding the sender until the block has delivered everything.
  task automatic test_random_scenes();
    int scene;
    int k;
    int r;
    for (scene = 0; scene < 8; scene++) begin
      wait_until_idle();
      write_screen_reg(REG_SCREEN_WIDTH, pick_screen_size());
      write_screen_reg(REG_SCREEN_HEIGHT, pick_screen_size());
      no_gaps = (scene == 3);
      load_matrices(scene != 6);
      for (k = 0; k < 60; k++) begin
        r = $urandom_range(99);
        if (r < 8) begin
          load_coeff($urandom_range(NCOEF - 1), fx_t'($urandom));
        end else if (r < 22) begin
          project(fx_t'($urandom), fx_t'($urandom), fx_t'($urandom));
        end else begin
          project(rand_between(-40 * FX_ONE, 40 * FX_ONE),
                  rand_between(-40 * FX_ONE, 40 * FX_ONE),
                  rand_between(-20 * FX_ONE, 120 * FX_ONE));
        end
      end
    end
    no_gaps = 1'b0;
  endtask

  // Requests with every field drawn from its whole range.
  task automatic test_random_requests();
    int k;
    for (k = 0; k < 60; k++) begin
      send_request(cmd_t'($urandom_range(1)), ADDR_W'($urandom), fx_t'($urandom),
                   fx_t'($urandom), fx_t'($urandom), fx_t'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin : run_tests
    int idx;
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid      = 1'b0;
    command       = CMD_LOAD;
    coeff_index   = '0;
    coeff_value   = '0;
    world_x       = '0;
    world_y       = '0;
    world_z       = '0;
    no_gaps       = 1'b0;
    mismatch_count = 0;
    width_mirror  = DIM_W'(1920);
    height_mirror = DIM_W'(1080);
    for (idx = 0; idx < NCOEF; idx++) begin
      coeff_mirror[idx] = '0;
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_directed_cases();
    test_screen_sizes();
    test_random_scenes();
    test_random_requests();

    wait_until_idle();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
